// ===== hdl/dedispersion_channel_shift_core_macros.svh =====
// Assertion macros for the dedispersion channel shift core.
// Used by the checker; expects clk and rst in scope.
`ifndef DEDISPERSION_CHANNEL_SHIFT_CORE_MACROS_SVH
`define DEDISPERSION_CHANNEL_SHIFT_CORE_MACROS_SVH

// Same-cycle implication
`define DCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dcs_pkg.sv =====
// Shared types and constants for the dedispersion channel shift core.
// No dependencies; used by every module of the block.
package dcs_pkg;

  // Field widths
  localparam int CH_W    = 6;
  localparam int TB_W    = 16;
  localparam int VAL_W   = 32;
  localparam int OTB_W   = 20;
  localparam int ST_W    = 2;

  // Configuration widths
  localparam int DM_W    = 24;
  localparam int FS_W    = 24;
  localparam int FSTEP_W = 21;
  localparam int TS_W    = 32;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 32;

  // Frequency arithmetic
  localparam int DIFF_W  = 27;
  localparam int FREQ_W  = 28;
  localparam int MAG_W   = 26;
  localparam int FU_W    = 27;
  localparam int SUM_W   = 28;

  // Numerator / denominator widths
  localparam int A_W     = 56;
  localparam int B_W     = 54;
  localparam int C_W     = 51;
  localparam int NUM_W   = 120;
  localparam int DSQ_W   = 102;
  localparam int DEN_W   = 134;
  localparam int QW      = 22;
  localparam int CMP_W   = DEN_W + QW;

  localparam logic [31:0] DELAY_CONST = 32'd4150000000;

  // Output range
  localparam int OUT_TIME_BINS = 1048576;
  localparam int T_MAX_RAW     = OUT_TIME_BINS - 1;
  localparam int T_MAX         = (T_MAX_RAW > 1048575) ? 1048575 : T_MAX_RAW;
  localparam logic [OTB_W-1:0] T_MAX_BIN = T_MAX[OTB_W-1:0];

  // Front-to-back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // Register reset values
  localparam logic [DM_W-1:0]           DM_RST    = 24'd0;
  localparam logic [FS_W-1:0]           FS_RST    = 24'd10240;
  localparam logic signed [FSTEP_W-1:0] FSTEP_RST = 21'sd1024;
  localparam logic [TS_W-1:0]           TS_RST    = 32'd83300;

  typedef enum logic [CFG_IW-1:0] {
    REG_DM     = 2'd0,
    REG_FSTART = 2'd1,
    REG_FSTEP  = 2'd2,
    REG_TSTEP  = 2'd3
  } reg_idx_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_CLAMP   = 2'd1,
    ST_BADFREQ = 2'd2
  } status_t;

  typedef struct packed {
    logic [DM_W-1:0]           dm;
    logic [FS_W-1:0]           f_start;
    logic signed [FSTEP_W-1:0] f_step;
    logic [TS_W-1:0]           time_step;
  } cfg_t;

  // Fields that ride along the pipeline untouched
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [TB_W-1:0]  tb;
    logic [VAL_W-1:0] val;
    logic             bad;
    logic             neg;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [MAG_W-1:0] mag;
    logic [FU_W-1:0]  fu;
  } item_t;

  // Handshake between front and queue
  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

// ===== hdl/dcs_front.sv =====
// Front end: configuration registers, input request capture, frequency classification.
// Depends on dcs_pkg.
module dcs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dcs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [dcs_pkg::CFG_DW-1:0]    cfg_data,
  output dcs_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dcs_pkg::CH_W-1:0]      channel,
  input  logic [dcs_pkg::TB_W-1:0]      time_bin,
  input  logic [dcs_pkg::VAL_W-1:0]     sample_value,
  input  logic                          q_full,
  output logic                          q_push,
  output dcs_pkg::item_t                q_item
);

  logic signed [dcs_pkg::DIFF_W-1:0] diff;
  logic signed [dcs_pkg::FREQ_W-1:0] freq;
  logic [dcs_pkg::DIFF_W-1:0]        absd;
  dcs_pkg::item_t                    cls;
  dcs_pkg::item_t                    fitem;
  logic                              fv;
  logic                              accept;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dm        <= dcs_pkg::DM_RST;
      cfg.f_start   <= dcs_pkg::FS_RST;
      cfg.f_step    <= dcs_pkg::FSTEP_RST;
      cfg.time_step <= dcs_pkg::TS_RST;
    end else if (cfg_valid) begin
      case (dcs_pkg::reg_idx_t'(cfg_index))
        dcs_pkg::REG_DM:     cfg.dm        <= cfg_data[dcs_pkg::DM_W-1:0];
        dcs_pkg::REG_FSTART: cfg.f_start   <= cfg_data[dcs_pkg::FS_W-1:0];
        dcs_pkg::REG_FSTEP:  cfg.f_step    <= signed'(cfg_data[dcs_pkg::FSTEP_W-1:0]);
        dcs_pkg::REG_TSTEP:  cfg.time_step <= cfg_data[dcs_pkg::TS_W-1:0];
        default: ;
      endcase
    end
  end

  // F - F0 and F for this channel
  assign diff = dcs_pkg::DIFF_W'($signed({1'b0, channel})) * dcs_pkg::DIFF_W'(cfg.f_step);
  assign freq = dcs_pkg::FREQ_W'($signed({1'b0, cfg.f_start})) + dcs_pkg::FREQ_W'(diff);
  assign absd = diff[dcs_pkg::DIFF_W-1] ? dcs_pkg::DIFF_W'(-diff) : dcs_pkg::DIFF_W'(diff);

  always_comb begin
    cls.side.ch  = channel;
    cls.side.tb  = time_bin;
    cls.side.val = sample_value;
    cls.side.bad = (freq <= 0) || (cfg.f_start == '0);
    cls.side.neg = diff[dcs_pkg::DIFF_W-1];
    cls.mag      = absd[dcs_pkg::MAG_W-1:0];
    cls.fu       = freq[dcs_pkg::FU_W-1:0];
  end

  assign in_ready = !fv || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = fv && !q_full;
  assign q_item   = fitem;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fitem <= cls;
    end
  end

endmodule

// ===== hdl/dcs_queue.sv =====
// Short queue between front and back ends.
// Depends on dcs_pkg.
module dcs_queue (
  input  logic           clk,
  input  logic           rst,
  input  dcs_pkg::item_t item_in,
  input  logic           push,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dcs_pkg::item_t head
);

  dcs_pkg::item_t            mem [dcs_pkg::Q_DEPTH];
  logic [dcs_pkg::Q_AW-1:0]  wr;
  logic [dcs_pkg::Q_AW-1:0]  rd;
  logic [dcs_pkg::Q_AW:0]    count;
  logic                      do_pop;

  assign full       = (count == (dcs_pkg::Q_AW + 1)'(dcs_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd];
  assign do_pop     = pop && head_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= wr + 1'b1;
      end
      if (do_pop) begin
        rd <= rd + 1'b1;
      end
      count <= count + (dcs_pkg::Q_AW + 1)'(push) - (dcs_pkg::Q_AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= item_in;
    end
  end

endmodule

// ===== hdl/dcs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation detect.
// Depends on dcs_pkg.
module dcs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [dcs_pkg::NUM_W-1:0] num,
  input  logic [dcs_pkg::DEN_W-1:0] den,
  input  dcs_pkg::side_t            side_in,
  output logic                      out_valid,
  output logic [dcs_pkg::QW-1:0]    quo,
  output logic                      sat,
  output dcs_pkg::side_t            side_out
);

  logic                      rv  [dcs_pkg::QW+1];
  logic [dcs_pkg::NUM_W-1:0] r   [dcs_pkg::QW];
  logic [dcs_pkg::DEN_W-1:0] d   [dcs_pkg::QW];
  logic [dcs_pkg::QW-1:0]    qq  [dcs_pkg::QW+1];
  logic                      st  [dcs_pkg::QW+1];
  dcs_pkg::side_t            sd  [dcs_pkg::QW+1];
  logic                      sat0;

  // Quotient would not fit in QW bits
  assign sat0 = dcs_pkg::CMP_W'(num) >= (dcs_pkg::CMP_W'(den) << dcs_pkg::QW);

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= num;
      d[0]  <= den;
      qq[0] <= '0;
      st[0] <= sat0;
      sd[0] <= side_in;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= dcs_pkg::QW; k++) begin : g_stage
    localparam int SH = dcs_pkg::QW - k;
    logic [dcs_pkg::CMP_W-1:0] shd;
    logic [dcs_pkg::CMP_W-1:0] rem;
    logic                      ge;

    assign shd = dcs_pkg::CMP_W'(d[k-1]) << SH;
    assign ge  = dcs_pkg::CMP_W'(r[k-1]) >= shd;
    assign rem = dcs_pkg::CMP_W'(r[k-1]) - shd;

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k] <= 1'b0;
      end else if (en) begin
        rv[k] <= rv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qq[k] <= qq[k-1] | (ge ? (dcs_pkg::QW'(1) << SH) : '0);
        st[k] <= st[k-1];
        sd[k] <= sd[k-1];
      end
    end

    // Divisor and partial remainder, needed up to the last stage only
    if (k < dcs_pkg::QW) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          d[k] <= d[k-1];
          r[k] <= ge ? rem[dcs_pkg::NUM_W-1:0] : r[k-1];
        end
      end
    end
  end

  assign out_valid = rv[dcs_pkg::QW];
  assign quo       = qq[dcs_pkg::QW];
  assign sat       = st[dcs_pkg::QW];
  assign side_out  = sd[dcs_pkg::QW];

endmodule

// ===== hdl/dcs_back.sv =====
// Back end: numerator and denominator products, divider, clamp and output register.
// Depends on dcs_pkg and dcs_div.
module dcs_back (
  input  logic                       clk,
  input  logic                       rst,
  input  dcs_pkg::cfg_t              cfg,
  input  logic                       q_valid,
  input  dcs_pkg::item_t             q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dcs_pkg::CH_W-1:0]   out_channel,
  output logic [dcs_pkg::OTB_W-1:0]  out_time_bin,
  output logic [dcs_pkg::VAL_W-1:0]  out_value,
  output logic [dcs_pkg::ST_W-1:0]   status
);

  localparam int PP_W = 55;
  localparam int PD_W = 52;
  localparam int CK_W = 26;
  localparam int PT_W = CK_W + dcs_pkg::TS_W;
  localparam int TW   = dcs_pkg::QW + 2;

  logic en;

  // Stage 1: first products
  logic                        v1;
  dcs_pkg::side_t              sd1;
  logic [dcs_pkg::A_W-1:0]     ma;
  logic [dcs_pkg::B_W-1:0]     mb;
  logic [dcs_pkg::C_W-1:0]     mc;
  logic [dcs_pkg::SUM_W-1:0]   fsum;

  // Stage 2: partial products
  logic                        v2;
  dcs_pkg::side_t              sd2;
  logic [PP_W-1:0]             pn00, pn01, pn10, pn11;
  logic [PD_W-1:0]             pd00, pd01, pd11;

  // Stage 3: numerator and (F0*F)^2
  logic                        v3;
  dcs_pkg::side_t              sd3;
  logic [dcs_pkg::NUM_W-1:0]   num3;
  logic [dcs_pkg::DSQ_W-1:0]   ds3;

  // Stage 4: times time_step, partial
  logic                        v4;
  dcs_pkg::side_t              sd4;
  logic [dcs_pkg::NUM_W-1:0]   num4;
  logic [PT_W-1:0]             pt [4];
  logic [4*CK_W-1:0]           dsx;
  logic [dcs_pkg::TS_W-1:0]    ts0;

  // Stage 5: full denominator
  logic                        v5;
  dcs_pkg::side_t              sd5;
  logic [dcs_pkg::NUM_W-1:0]   num5;
  logic [dcs_pkg::DEN_W-1:0]   den5;

  // Divider output
  logic                        vd;
  logic [dcs_pkg::QW-1:0]      qd;
  logic                        satd;
  dcs_pkg::side_t              sdd;

  // Final clamp
  logic [TW-1:0]               tbx, qx, tsum;
  logic [dcs_pkg::OTB_W-1:0]   tout;
  dcs_pkg::status_t            st_next;

  // Whole pipeline advances unless the output holds an untaken result
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  assign fsum = dcs_pkg::SUM_W'(q_item.fu) + dcs_pkg::SUM_W'(cfg.f_start);
  assign ts0  = (cfg.time_step == '0) ? dcs_pkg::TS_W'(1) : cfg.time_step;
  assign dsx  = (4*CK_W)'(ds3);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Product pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      sd1  <= q_item.side;
      ma   <= dcs_pkg::A_W'(cfg.dm) * dcs_pkg::A_W'(dcs_pkg::DELAY_CONST);
      mb   <= dcs_pkg::B_W'(q_item.mag) * dcs_pkg::B_W'(fsum);
      mc   <= dcs_pkg::C_W'(cfg.f_start) * dcs_pkg::C_W'(q_item.fu);

      sd2  <= sd1;
      pn00 <= PP_W'(ma[27:0])  * PP_W'(mb[26:0]);
      pn01 <= PP_W'(ma[27:0])  * PP_W'(mb[53:27]);
      pn10 <= PP_W'(ma[55:28]) * PP_W'(mb[26:0]);
      pn11 <= PP_W'(ma[55:28]) * PP_W'(mb[53:27]);
      pd00 <= PD_W'(mc[25:0])  * PD_W'(mc[25:0]);
      pd01 <= PD_W'(mc[25:0])  * PD_W'(mc[50:26]);
      pd11 <= PD_W'(mc[50:26]) * PD_W'(mc[50:26]);

      sd3  <= sd2;
      num3 <= (dcs_pkg::NUM_W'(pn11) << 65) + (dcs_pkg::NUM_W'(pn10) << 38)
            + (dcs_pkg::NUM_W'(pn01) << 37) + (dcs_pkg::NUM_W'(pn00) << 10);
      ds3  <= (dcs_pkg::DSQ_W'(pd11) << 52) + (dcs_pkg::DSQ_W'(pd01) << 27)
            + dcs_pkg::DSQ_W'(pd00);

      sd4  <= sd3;
      num4 <= num3;
      for (int k = 0; k < 4; k++) begin
        pt[k] <= PT_W'(dsx[k*CK_W +: CK_W]) * PT_W'(ts0);
      end

      sd5  <= sd4;
      num5 <= num4;
      den5 <= dcs_pkg::DEN_W'(pt[0]) + (dcs_pkg::DEN_W'(pt[1]) << CK_W)
            + (dcs_pkg::DEN_W'(pt[2]) << (2*CK_W)) + (dcs_pkg::DEN_W'(pt[3]) << (3*CK_W));
    end
  end

  dcs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .num       (num5),
    .den       (den5),
    .side_in   (sd5),
    .out_valid (vd),
    .quo       (qd),
    .sat       (satd),
    .side_out  (sdd)
  );

  // Shift, clamp and status
  assign tbx  = TW'(sdd.tb);
  assign qx   = TW'(qd);
  assign tsum = sdd.neg ? (tbx - qx) : (tbx + qx);

  always_comb begin
    if (sdd.bad) begin
      tout    = '0;
      st_next = dcs_pkg::ST_BADFREQ;
    end else if (satd) begin
      tout    = sdd.neg ? '0 : dcs_pkg::T_MAX_BIN;
      st_next = dcs_pkg::ST_CLAMP;
    end else if (tsum[TW-1]) begin
      tout    = '0;
      st_next = dcs_pkg::ST_CLAMP;
    end else if (tsum > TW'(dcs_pkg::T_MAX)) begin
      tout    = dcs_pkg::T_MAX_BIN;
      st_next = dcs_pkg::ST_CLAMP;
    end else begin
      tout    = tsum[dcs_pkg::OTB_W-1:0];
      st_next = dcs_pkg::ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_channel  <= sdd.ch;
      out_time_bin <= tout;
      out_value    <= sdd.val;
      status       <= st_next;
    end
  end

endmodule

// ===== hdl/dedispersion_channel_shift_core.sv =====
// Dedispersion channel shift core. Each request (channel, time bin, sample word)
// returns one result with its dispersion-shifted, clamped output time bin; one
// request per clock is sustained while results are taken. A request passes the
// input register and queue, five multiply stages building the exact numerator
// and denominator, a saturation check and a 22-stage restoring divider, then
// the output register. A stalled result freezes the whole back pipeline;
// the input side keeps taking requests until the input register and the
// two-entry queue are full. Configuration writes are taken every cycle and must
// only happen while no request is in flight.
module dedispersion_channel_shift_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dcs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [dcs_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dcs_pkg::CH_W-1:0]      channel,
  input  logic [dcs_pkg::TB_W-1:0]      time_bin,
  input  logic [dcs_pkg::VAL_W-1:0]     sample_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dcs_pkg::CH_W-1:0]      out_channel,
  output logic [dcs_pkg::OTB_W-1:0]     out_time_bin,
  output logic [dcs_pkg::VAL_W-1:0]     out_value,
  output logic [dcs_pkg::ST_W-1:0]      status
);

  dcs_pkg::cfg_t  cfg;
  dcs_pkg::item_t push_item;
  dcs_pkg::item_t head;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;

  dcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .channel      (channel),
    .time_bin     (time_bin),
    .sample_value (sample_value),
    .q_full       (full),
    .q_push       (push),
    .q_item       (push_item)
  );

  dcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .item_in    (push_item),
    .push       (push),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (head_valid),
    .q_item       (head),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .out_time_bin (out_time_bin),
    .out_value    (out_value),
    .status       (status)
  );

endmodule

// ===== hdl/dcs_checker.sv =====
// Port-level checks for the dedispersion channel shift core, bound to the top level.
// Depends on dcs_pkg and dedispersion_channel_shift_core_macros.svh.
`include "dedispersion_channel_shift_core_macros.svh"

module dcs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dcs_pkg::OTB_W-1:0]     out_time_bin,
  input logic [dcs_pkg::VAL_W-1:0]     out_value,
  input logic [dcs_pkg::ST_W-1:0]      status
);

  // A stalled result keeps its payload
  `DCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_time_bin) && $stable(status), "stalled result changed")

  // Bad frequency results carry bin zero
  `DCS_ASSERT_IMP(a_bad_zero, out_valid && status == dcs_pkg::ST_BADFREQ, out_time_bin == '0, "bad-frequency result with nonzero bin")

  // Clamped results sit on a range edge
  `DCS_ASSERT_IMP(a_clamp_edge, out_valid && status == dcs_pkg::ST_CLAMP, out_time_bin == '0 || out_time_bin == dcs_pkg::T_MAX_BIN, "clamped bin not at range edge")

  // After reset falls or on a config write, the input side or the config port is ready
  `DCS_ASSERT_IMP(a_ready_after_rst, $fell(rst) || cfg_valid, in_ready || cfg_ready, "ports not ready")

endmodule

bind dedispersion_channel_shift_core dcs_checker u_dcs_checker (.*);
